>>> sv/kva_pkg.sv
// ----------------------------------------------------------------------------
// kva_pkg: shared definitions for the linear key/value array
// Sizes, action codes and the structs that pass between the top level and
// the chain of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kva_pkg;

	localparam int ENTRIES = 64;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int FILL_W  = $clog2(ENTRIES + 1);

	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_GET   = 2'd1,
		ACT_COUNT = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	// Request broadcast to every cell while a search walks the chain.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             is_set;
	} req_t;

	// Token and partial result handed from one cell to the next.
	typedef struct packed {
		logic             go;
		logic             done;
		logic             hit;
		logic             claim;
		logic [VAL_W-1:0] rdval;
	} link_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             hit;
		count_t           occupied_count;
		logic             table_full;
		logic             bad_key;
	} result_t;

	// The reported count is the fill level modulo 2**CNT_W.
	function automatic count_t to_count(input fill_t fill);
		logic [FILL_W+CNT_W-1:0] wide;
		wide = {{CNT_W{1'b0}}, fill};
		return wide[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/kva_req_if.sv
// ----------------------------------------------------------------------------
// kva_req_if: request channel
// Valid/ready channel carrying one action with its key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface kva_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [kva_pkg::KEY_W-1:0] item_key;
	logic [kva_pkg::VAL_W-1:0] item_value;

	modport source (output valid, output action, output item_key, output item_value,
		input ready);
	modport sink (input valid, input action, input item_key, input item_value,
		output ready);
endinterface

`default_nettype wire

>>> sv/kva_rsp_if.sv
// ----------------------------------------------------------------------------
// kva_rsp_if: response channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface kva_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [kva_pkg::VAL_W-1:0] read_value;
	logic                      hit;
	logic [kva_pkg::CNT_W-1:0] occupied_count;
	logic                      table_full;
	logic                      bad_key;

	modport source (output valid, output read_value, output hit, output occupied_count,
		output table_full, output bad_key, input ready);
	modport sink (input valid, input read_value, input hit, input occupied_count,
		input table_full, input bad_key, output ready);
endinterface

`default_nettype wire

>>> sv/kva_cell.sv
// ----------------------------------------------------------------------------
// kva_cell: one key/value slot of the chain
// Compares the broadcast key when the search token arrives, updates or
// claims its slot, and hands the token on to the next cell through its link register.
// ----------------------------------------------------------------------------
`default_nettype none

module kva_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire kva_pkg::req_t  req,
	input  wire logic           clear,
	input  wire kva_pkg::link_t link_in,
	output kva_pkg::link_t      link_out
);

	logic                      valid_q;
	logic [kva_pkg::KEY_W-1:0] key_q;
	logic [kva_pkg::VAL_W-1:0] val_q;
	kva_pkg::link_t            link_q;
	kva_pkg::link_t            link_d;
	logic                      active;
	logic                      match;

	assign active   = link_in.go && !link_in.done;
	assign match    = valid_q && (key_q == req.key);
	assign link_out = link_q;

	// The token passes through unchanged unless this cell settles the search.
	always_comb begin
		link_d = link_in;
		if (!clear && active) begin
			if (match) begin
				link_d.done = 1'b1;
				link_d.hit  = 1'b1;
				if (!req.is_set) begin
					link_d.rdval = val_q;
				end
			end else if (!valid_q) begin
				// First free slot: the key is absent from the table.
				link_d.done = 1'b1;
				if (req.is_set) begin
					link_d.claim = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			link_q  <= '0;
		end else begin
			link_q <= link_d;
			if (clear) begin
				valid_q <= 1'b0;
			end else if (active && !valid_q && req.is_set) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Slot contents need no reset; the valid bit qualifies them.
	always_ff @(posedge clk) begin
		if (active && (match || !valid_q) && req.is_set) begin
			val_q <= req.value;
		end
		if (active && !valid_q && req.is_set) begin
			key_q <= req.key;
		end
	end

endmodule

`default_nettype wire

>>> sv/linear_key_value_array.sv
// ----------------------------------------------------------------------------
// linear_key_value_array: key/value table searched along a chain of cells
// A set stores a value under a key, a get returns it, count reports the
// number of occupied slots and clear frees them all.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Beat contents
//   request    in         action, item_key, item_value
//   response   out        read_value, hit, occupied_count, table_full, bad_key
//
// A set or get with a nonzero key sends a token down the chain of ENTRIES
// cells, one cell per cycle, and the search result is registered as the response beat.
// Count, clear and bad-key requests are answered directly, without a search.
// The chain length sets the search latency; one request is in work at a time.
// Reset empties every slot at once; there is no clearing sweep.
// A stalled response is held in the output register; one further finished
// result waits in a holding register, and the request side stalls then and during a search.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_array (
	input  wire logic clk,
	input  wire logic arst_n,
	kva_req_if.sink   request,
	kva_rsp_if.source response
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_HOLD
	} state_t;

	state_t             state_q;
	kva_pkg::fill_t     fill_q;
	kva_pkg::req_t      req_q;
	logic               start_q;
	kva_pkg::result_t   out_q;
	logic               out_valid_q;
	kva_pkg::result_t   pend_q;

	kva_pkg::action_t   act;
	logic               accept;
	logic               key_zero;
	logic               is_search;
	logic               is_clear;
	logic               slot_free;
	logic               out_load;
	logic               chain_end;
	kva_pkg::result_t   imm_res;
	kva_pkg::result_t   walk_res;
	kva_pkg::link_t     link [0:kva_pkg::ENTRIES];

	// Decode of the incoming beat. Searches are sets and gets with a legal key;
	// everything else is answered directly from the fill level.
	assign act       = kva_pkg::action_t'(request.action);
	assign request.ready = (state_q == ST_IDLE);
	assign accept    = request.valid && request.ready;
	assign key_zero  = (request.item_key == '0);
	assign is_search = ((act == kva_pkg::ACT_SET) || (act == kva_pkg::ACT_GET)) && !key_zero;
	assign is_clear  = accept && (act == kva_pkg::ACT_CLEAR);

	// The output register can take a new result when it is empty or draining.
	assign slot_free = !out_valid_q || response.ready;
	assign chain_end = link[kva_pkg::ENTRIES].go;

	// A result enters the output register this cycle: a direct answer, the end
	// of a search, or the result parked in the holding register.
	assign out_load = slot_free && (((state_q == ST_IDLE) && accept && !is_search) ||
		((state_q == ST_WALK) && chain_end) || (state_q == ST_HOLD));

	always_comb begin
		imm_res            = '0;
		imm_res.bad_key    = (act == kva_pkg::ACT_SET) || (act == kva_pkg::ACT_GET);
		imm_res.occupied_count = (act == kva_pkg::ACT_CLEAR) ? '0 : kva_pkg::to_count(fill_q);

		// The token leaves the last cell with the search outcome. A set that
		// neither hit nor found a free slot was dropped because the table is full.
		walk_res            = '0;
		walk_res.read_value = link[kva_pkg::ENTRIES].rdval;
		walk_res.hit        = link[kva_pkg::ENTRIES].hit;
		walk_res.table_full = req_q.is_set && !link[kva_pkg::ENTRIES].done;
		walk_res.occupied_count =
			kva_pkg::to_count(fill_q + kva_pkg::fill_t'(link[kva_pkg::ENTRIES].claim));
	end

	// The token enters cell 0 from the start register, set when the request is captured.
	always_comb begin
		link[0]       = '0;
		link[0].go    = start_q;
	end

	for (genvar i = 0; i < kva_pkg::ENTRIES; i++) begin : g_cell
		kva_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.clear    (is_clear),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			req_q       <= '0;
			start_q     <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= '0;
		end else begin
			start_q <= accept && is_search;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_search) begin
							req_q.key    <= request.item_key;
							req_q.value  <= request.item_value;
							req_q.is_set <= (act == kva_pkg::ACT_SET);
							state_q      <= ST_WALK;
						end else begin
							if (act == kva_pkg::ACT_CLEAR) begin
								fill_q <= '0;
							end
							if (slot_free) begin
								out_q <= imm_res;
							end else begin
								pend_q  <= imm_res;
								state_q <= ST_HOLD;
							end
						end
					end
				end
				ST_WALK: begin
					if (chain_end) begin
						fill_q <= fill_q + kva_pkg::fill_t'(link[kva_pkg::ENTRIES].claim);
						if (slot_free) begin
							out_q   <= walk_res;
							state_q <= ST_IDLE;
						end else begin
							pend_q  <= walk_res;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						out_q   <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign response.valid          = out_valid_q;
	assign response.read_value     = out_q.read_value;
	assign response.hit            = out_q.hit;
	assign response.occupied_count = out_q.occupied_count;
	assign response.table_full     = out_q.table_full;
	assign response.bad_key        = out_q.bad_key;

endmodule

`default_nettype wire
